FILE: src/mqsb_pkg.sv
// shared types and constants for the multi-queue shared buffer
`timescale 1ns / 1ps

package mqsb_pkg;

    localparam int KIND_W = 1;
    localparam int QN_W   = 3;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;

    localparam logic [KIND_W-1:0] KIND_ENQ = 1'b0;
    localparam logic [KIND_W-1:0] KIND_DEQ = 1'b1;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic load;
        logic commit;
    } cmd_t;

endpackage

FILE: src/mqsb_ctrl.sv
// controller for the multi-queue shared buffer: accept, execute, output handshake
`timescale 1ns / 1ps

module mqsb_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output mqsb_pkg::cmd_t   cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic m_tvalid_reg;
    logic m_tvalid_next;

    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.load   = s_tvalid && s_tready;
    assign cmd.commit = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign m_tvalid   = m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd.commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.commit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_load_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> (state_reg == ST_EXEC))
        else $error("accepted beat did not move to execute");

    a_commit_gives_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid_reg)
        else $error("result beat missing after commit");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !cmd.commit)
        else $error("pending result overwritten");

endmodule

FILE: src/mqsb_dp.sv
// datapath for the multi-queue shared buffer: slot store, link table, queue pointers
`timescale 1ns / 1ps

module mqsb_dp #(
    parameter int NUM_QUEUES = 8,
    parameter int SLOTS      = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mqsb_pkg::cmd_t                    cmd,
    input  logic [mqsb_pkg::KIND_W-1:0]       kind,
    input  logic [mqsb_pkg::QN_W-1:0]         queue_number,
    input  logic signed [mqsb_pkg::DATA_W-1:0] value,
    output logic [mqsb_pkg::ST_W-1:0]         status,
    output logic signed [mqsb_pkg::DATA_W-1:0] read_value
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = $clog2(SLOTS + 1);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam logic [LW-1:0] NIL = LW'(SLOTS);

    logic [mqsb_pkg::DATA_W-1:0] data_mem [SLOTS];
    logic [LW-1:0]               link_mem [SLOTS];

    logic [LW-1:0] head_reg [NUM_QUEUES];
    logic [LW-1:0] tail_reg [NUM_QUEUES];
    logic [LW-1:0] free_head_reg;
    logic [LW-1:0] free_head_next;
    logic [LW-1:0] fresh_reg;
    logic [LW-1:0] fresh_next;

    logic [mqsb_pkg::KIND_W-1:0] kind_reg;
    logic [mqsb_pkg::QN_W-1:0]   q_reg;
    logic [mqsb_pkg::DATA_W-1:0] value_reg;
    logic [LW-1:0]               link_rd_reg;
    logic [mqsb_pkg::DATA_W-1:0] data_rd_reg;
    logic [mqsb_pkg::ST_W-1:0]   status_reg;
    logic [mqsb_pkg::ST_W-1:0]   status_next;
    logic [mqsb_pkg::DATA_W-1:0] read_value_reg;
    logic [mqsb_pkg::DATA_W-1:0] read_value_next;

    logic [QW-1:0] q_in_idx;
    logic [SW-1:0] rd_addr;
    logic [QW-1:0] q_idx;
    logic          q_ok;
    logic [LW-1:0] cur_head;
    logic [LW-1:0] cur_tail;
    logic          head_live;
    logic          tail_live;
    logic          fresh_hit;
    logic [LW-1:0] pop_next;
    logic [LW-1:0] deq_next;
    logic          enq_ok;
    logic          deq_ok;

    logic          head_wr;
    logic [LW-1:0] head_next;
    logic          tail_wr;
    logic [LW-1:0] tail_next;
    logic          link_we;
    logic [SW-1:0] link_wa;
    logic [LW-1:0] link_wd;
    logic          data_we;

    // read address chosen on the accepted beat
    assign q_in_idx = QW'(queue_number);
    assign rd_addr  = (kind == mqsb_pkg::KIND_DEQ) ? head_reg[q_in_idx][SW-1:0]
                                                   : free_head_reg[SW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg    <= kind;
            q_reg       <= queue_number;
            value_reg   <= value;
            link_rd_reg <= link_mem[rd_addr];
            data_rd_reg <= data_mem[rd_addr];
        end
    end

    assign q_idx     = QW'(q_reg);
    assign q_ok      = 32'(q_reg) < 32'(NUM_QUEUES);
    assign cur_head  = head_reg[q_idx];
    assign cur_tail  = tail_reg[q_idx];
    assign head_live = cur_head < NIL;
    assign tail_live = cur_tail < NIL;
    // slots at or above the fill count were never written and still chain to the next slot
    assign fresh_hit = free_head_reg >= fresh_reg;
    assign pop_next  = fresh_hit ? (free_head_reg + LW'(1)) : link_rd_reg;
    // the tail slot ends its queue, its stored link is not kept
    assign deq_next  = (cur_head == cur_tail) ? NIL : link_rd_reg;
    assign enq_ok    = (kind_reg == mqsb_pkg::KIND_ENQ) && q_ok && (free_head_reg < NIL);
    assign deq_ok    = (kind_reg == mqsb_pkg::KIND_DEQ) && q_ok && head_live;

    always_comb begin
        free_head_next  = free_head_reg;
        fresh_next      = fresh_reg;
        head_wr         = 1'b0;
        head_next       = cur_head;
        tail_wr         = 1'b0;
        tail_next       = cur_tail;
        link_we         = 1'b0;
        link_wa         = cur_tail[SW-1:0];
        link_wd         = free_head_reg;
        data_we         = 1'b0;
        read_value_next = '0;
        status_next     = mqsb_pkg::ST_DONE;
        if (enq_ok) begin
            free_head_next = (pop_next < NIL) ? pop_next : NIL;
            if (fresh_hit) begin
                fresh_next = free_head_reg + LW'(1);
            end
            if (!head_live || !tail_live) begin
                head_wr   = 1'b1;
                head_next = free_head_reg;
            end else begin
                link_we = 1'b1;
                link_wa = cur_tail[SW-1:0];
                link_wd = free_head_reg;
            end
            tail_wr   = 1'b1;
            tail_next = free_head_reg;
            data_we   = 1'b1;
        end else if (deq_ok) begin
            head_wr   = 1'b1;
            head_next = (deq_next < NIL) ? deq_next : NIL;
            if (!(deq_next < NIL)) begin
                tail_wr   = 1'b1;
                tail_next = NIL;
            end
            link_we         = 1'b1;
            link_wa         = cur_head[SW-1:0];
            link_wd         = free_head_reg;
            free_head_next  = cur_head;
            read_value_next = data_rd_reg;
        end else if (kind_reg == mqsb_pkg::KIND_ENQ) begin
            status_next = mqsb_pkg::ST_FULL;
        end else begin
            status_next = mqsb_pkg::ST_EMPTY;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        if (cmd.commit && data_we) begin
            data_mem[free_head_reg[SW-1:0]] <= value_reg;
        end
        if (cmd.commit) begin
            status_reg     <= status_next;
            read_value_reg <= read_value_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= '0;
            fresh_reg     <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
        end else if (cmd.commit) begin
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            if (head_wr) begin
                head_reg[q_idx] <= head_next;
            end
            if (tail_wr) begin
                tail_reg[q_idx] <= tail_next;
            end
        end
    end

    assign status     = status_reg;
    assign read_value = read_value_reg;

    a_free_head_range: assert property (@(posedge aclk) disable iff (!aresetn)
        free_head_reg <= NIL)
        else $error("free head out of range");

    a_fresh_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fresh_reg <= NIL)
        else $error("fill count out of range");

    a_enq_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && enq_ok) |=> (tail_reg[$past(q_idx)] == $past(free_head_reg)))
        else $error("enqueued slot not placed at tail");

endmodule

FILE: src/multi_queue_shared_buffer.sv
// top level of the multi-queue shared buffer
//
//  channel | direction | tdata                          | tuser
//  s_      | in        | queue_number[2:0] value[34:3]  | kind
//  m_      | out       | read_value[31:0]               | status
//
// each item is read, then executed: the accept cycle reads the link table and slot store into registers,
// the execute state then updates pointers and writes the single-port link table
// a new beat is accepted while the previous result waits on m_
// execute holds while the result register is still full
// aresetn is synchronous; pointers and fill count reset at once, no clearing pass
`timescale 1ns / 1ps

module multi_queue_shared_buffer #(
    parameter int NUM_QUEUES = 8,
    parameter int SLOTS      = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // queue_number[2:0], value[34:3], zero fill
    input  logic [0:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_value[31:0]
    output logic [1:0]  m_tuser    // status
);

    mqsb_pkg::cmd_t cmd;

    mqsb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    mqsb_dp #(
        .NUM_QUEUES (NUM_QUEUES),
        .SLOTS      (SLOTS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .kind         (s_tuser),
        .queue_number (s_tdata[2:0]),
        .value        (s_tdata[34:3]),
        .status       (m_tuser),
        .read_value   (m_tdata)
    );

endmodule

FILE: bench/multi_queue_shared_buffer_tb.sv
// self-checking testbench for the multi-queue shared buffer with a shadow model scoreboard
`timescale 1ns / 1ps

module multi_queue_shared_buffer_tb;

    localparam int NQ         = 8;
    localparam int NSLOT      = 64;
    localparam logic [6:0] NIL = 7'(NSLOT);
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_CAP   = 40;

    typedef struct {
        logic [mqsb_pkg::ST_W-1:0]   status;
        logic [mqsb_pkg::DATA_W-1:0] read_value;
    } result_t;

    class mqsb_shadow;
        logic [mqsb_pkg::DATA_W-1:0] slot_data [NSLOT];
        logic [6:0]                  slot_link [NSLOT];
        logic [6:0]                  q_head [NQ];
        logic [6:0]                  q_tail [NQ];
        logic [6:0]                  free_ptr;
        result_t                     awaited [$];
        int errors;
        int enq_ok, enq_full, deq_ok, deq_empty;

        function new();
            for (int i = 0; i < NSLOT; i++) begin
                slot_data[i] = '0;
                slot_link[i] = 7'(i + 1);
            end
            slot_link[NSLOT-1] = NIL;
            for (int i = 0; i < NQ; i++) begin
                q_head[i] = NIL;
                q_tail[i] = NIL;
            end
            free_ptr = '0;
            errors = 0;
            enq_ok = 0;
            enq_full = 0;
            deq_ok = 0;
            deq_empty = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // update the shadow state for one accepted beat and queue its result
        function void note_beat(logic [mqsb_pkg::KIND_W-1:0] kind,
                                logic [mqsb_pkg::QN_W-1:0] qn,
                                logic [mqsb_pkg::DATA_W-1:0] value);
            result_t r;
            logic [6:0] s;
            r.status = mqsb_pkg::ST_DONE;
            r.read_value = '0;
            if (kind == mqsb_pkg::KIND_ENQ) begin
                if (free_ptr >= NIL) begin
                    r.status = mqsb_pkg::ST_FULL;
                    enq_full++;
                end else begin
                    s = free_ptr;
                    free_ptr = (slot_link[s] < NIL) ? slot_link[s] : NIL;
                    if (q_head[qn] >= NIL || q_tail[qn] >= NIL)
                        q_head[qn] = s;
                    else
                        slot_link[q_tail[qn]] = s;
                    q_tail[qn] = s;
                    slot_link[s] = NIL;
                    slot_data[s] = value;
                    enq_ok++;
                end
            end else begin
                if (q_head[qn] >= NIL) begin
                    r.status = mqsb_pkg::ST_EMPTY;
                    deq_empty++;
                end else begin
                    s = q_head[qn];
                    q_head[qn] = (slot_link[s] < NIL) ? slot_link[s] : NIL;
                    if (q_head[qn] >= NIL)
                        q_tail[qn] = NIL;
                    slot_link[s] = free_ptr;
                    free_ptr = s;
                    r.read_value = slot_data[s];
                    deq_ok++;
                end
            end
            awaited.insert(awaited.size(), r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_beat(logic [mqsb_pkg::ST_W-1:0] status,
                        logic [mqsb_pkg::DATA_W-1:0] read_value);
            result_t r;
            if (awaited.size() == 0) begin
                report($sformatf("result beat with nothing outstanding, status %0d data %h",
                                 status, read_value));
            end else begin
                r = awaited.pop_front();
                if (status !== r.status)
                    report($sformatf("status %0d, wanted %0d", status, r.status));
                if (read_value !== r.read_value)
                    report($sformatf("read_value %h, wanted %h", read_value, r.read_value));
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // queue_number[2:0], value[34:3], zero fill
    logic [0:0]  s_tuser;   // kind
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // read_value[31:0]
    logic [1:0]  m_tuser;   // status

    mqsb_shadow sb;
    bit calm;
    int hold_cycles;
    int sent;

    multi_queue_shared_buffer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result side: random back-pressure bursts plus one long hold on request
    initial begin
        int gap;
        m_tready = 1'b0;
        gap = 0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else if (calm || !aresetn) begin
                m_tready <= 1'b1;
            end else if (gap > 0) begin
                gap--;
                m_tready <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 9) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat(m_tuser, m_tdata);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout with %0d results outstanding", sb.pending());
        $display("Verification failed");
        $finish;
    end

    task send_beat(logic [mqsb_pkg::KIND_W-1:0] kind, logic [mqsb_pkg::QN_W-1:0] qn,
                   logic [mqsb_pkg::DATA_W-1:0] value);
        int n;
        if (!calm && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 9);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, value, qn};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(kind, qn, value);
        sent++;
    endtask

    // stop offering beats until every outstanding result has come back
    task drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int enq_pct [10];
        int focus;
        logic [mqsb_pkg::QN_W-1:0] qn;
        logic [mqsb_pkg::KIND_W-1:0] kind;

        enq_pct = '{90, 30, 70, 10, 85, 50, 95, 20, 60, 40};
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = mqsb_pkg::KIND_ENQ;
        aresetn  = 1'b0;
        calm = 1'b0;
        hold_cycles = 0;
        sent = 0;
        sb = new();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty dequeues, extreme values, fifo order per queue
        send_beat(mqsb_pkg::KIND_DEQ, 3'd0, 32'h0);
        send_beat(mqsb_pkg::KIND_DEQ, 3'd7, 32'hFFFF_FFFF);
        send_beat(mqsb_pkg::KIND_ENQ, 3'd0, 32'h8000_0000);
        send_beat(mqsb_pkg::KIND_ENQ, 3'd0, 32'h7FFF_FFFF);
        send_beat(mqsb_pkg::KIND_ENQ, 3'd7, 32'h0000_0000);
        send_beat(mqsb_pkg::KIND_ENQ, 3'd7, 32'hFFFF_FFFF);
        send_beat(mqsb_pkg::KIND_ENQ, 3'd3, 32'h5555_5555);
        send_beat(mqsb_pkg::KIND_ENQ, 3'd3, 32'hAAAA_AAAA);
        send_beat(mqsb_pkg::KIND_DEQ, 3'd0, 32'h0);
        send_beat(mqsb_pkg::KIND_DEQ, 3'd7, 32'h0);
        send_beat(mqsb_pkg::KIND_DEQ, 3'd0, 32'h0);
        send_beat(mqsb_pkg::KIND_DEQ, 3'd3, 32'h0);
        send_beat(mqsb_pkg::KIND_DEQ, 3'd0, 32'h1234_5678);
        send_beat(mqsb_pkg::KIND_ENQ, 3'd7, 32'h1234_5678);
        send_beat(mqsb_pkg::KIND_DEQ, 3'd3, 32'h0);
        send_beat(mqsb_pkg::KIND_DEQ, 3'd7, 32'h0);
        send_beat(mqsb_pkg::KIND_DEQ, 3'd7, 32'h0);
        send_beat(mqsb_pkg::KIND_DEQ, 3'd7, 32'h0);
        send_beat(mqsb_pkg::KIND_DEQ, 3'd3, 32'h0);
        drain_results();

        // random phases alternate between filling the store and emptying queues
        for (int p = 0; p < 11; p++) begin
            if (p == 10)
                calm = 1'b1;
            focus = $urandom_range(0, NQ - 1);
            for (int i = 0; i < ((p == 10) ? 60 : 100); i++) begin
                if (p == 2 && i == 20)
                    hold_cycles = 300;
                if ($urandom_range(0, 1) == 0)
                    qn = mqsb_pkg::QN_W'(focus);
                else
                    qn = mqsb_pkg::QN_W'($urandom_range(0, NQ - 1));
                kind = ($urandom_range(0, 99) < enq_pct[p % 10]) ? mqsb_pkg::KIND_ENQ
                                                                  : mqsb_pkg::KIND_DEQ;
                send_beat(kind, qn, $urandom);
            end
            drain_results();
        end

        repeat (10) @(posedge aclk);
        $display("%0d beats: %0d enqueued, %0d refused full, %0d dequeued, %0d found empty",
                 sent, sb.enq_ok, sb.enq_full, sb.deq_ok, sb.deq_empty);
        $display("%0d mismatches after fill, drain and long output stall phases", sb.errors);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/mqsb_pkg.sv
src/mqsb_ctrl.sv
src/mqsb_dp.sv
src/multi_queue_shared_buffer.sv
bench/multi_queue_shared_buffer_tb.sv
